// ===== rtl/core/bpa_pkg.sv =====
// ============================================================================
// bpa_pkg
// Shared constants, codes and control structures of the bitmap page
// allocator: sizes of the used-page bitmap, result codes, controller states
// and the command and status groups between controller and datapath.
// ============================================================================
`default_nettype none

package bpa_pkg;

    // Bitmap geometry.
    localparam int PAGES     = 4096;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = PAGES / WORD_BITS;
    localparam int WORD_W    = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int PAGE_W    = $clog2(PAGES);
    localparam int CNT_W     = PAGE_W + 1;

    // Result codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    // Operation codes.
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_ASCAN,
        S_FCHK,
        S_CRD,
        S_CCLR,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_en;
        logic addr_step;
        logic addr_reload;
        logic wr_alloc;
        logic wr_clear;
        logic total_sub;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_free;
        logic lim_zero;
        logic cnt_zero;
        logic range_err;
        logic eval_last;
        logic alloc_found;
        logic free_ok;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/bpa_datapath.sv =====
// ============================================================================
// bpa_datapath
// Bitmap memory with per-row valid bits, read register, word evaluation for
// allocate and free, used-page counter and the tracked-entry register.
// ============================================================================
`default_nettype none

module bpa_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire bpa_pkg::t_dp_cmd          i_cmd,
    output bpa_pkg::t_dp_sts               o_sts,
    input  wire logic                      i_operation,
    input  wire logic [bpa_pkg::PAGE_W-1:0] i_page_index,
    input  wire logic [bpa_pkg::CNT_W-1:0] i_page_count,
    input  wire logic                      i_cfg_we,
    input  wire logic [bpa_pkg::CNT_W-1:0] i_cfg_data,
    output logic [bpa_pkg::PAGE_W-1:0]     o_granted,
    output logic [bpa_pkg::CNT_W-1:0]      o_total
);
    import bpa_pkg::*;

    localparam logic [CNT_W-1:0] PAGES_C = CNT_W'(PAGES);

    // Bitmap storage and row valid bits (a row never written reads as free).
    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_row_vld;

    logic [WORD_BITS-1:0] r_rd_data;
    logic [WORD_W-1:0]    r_rd_word;
    logic [WORD_W-1:0]    r_addr;

    // Per-item registers.
    logic                 r_op;
    logic [PAGE_W-1:0]    r_first;
    logic [PAGE_W-1:0]    r_last;
    logic [CNT_W-1:0]     r_count;
    logic [PAGE_W-1:0]    r_alloc_hi;
    logic                 r_lim_zero;
    logic                 r_range_err;
    logic                 r_cnt_zero;
    logic [PAGE_W-1:0]    r_granted;
    logic [CNT_W-1:0]     r_total;
    logic [CNT_W-1:0]     r_entries;

    logic [CNT_W-1:0]     lim;
    logic [CNT_W-1:0]     lim_m1;
    logic [CNT_W:0]       run_end;
    logic [CNT_W-1:0]     last_full;
    logic [WORD_W-1:0]    end_word;
    logic [WORD_BITS-1:0] alloc_mask;
    logic [WORD_BITS-1:0] avail;
    logic [BIT_W-1:0]     free_bit;
    logic [BIT_W-1:0]     lo;
    logic [BIT_W-1:0]     hi;
    logic [WORD_BITS-1:0] run_mask;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    // Load-time arithmetic on the incoming item.
    always_comb begin
        lim       = (r_entries > PAGES_C) ? PAGES_C : r_entries;
        lim_m1    = lim - CNT_W'(1);
        run_end   = {2'b00, i_page_index} + {1'b0, i_page_count};
        last_full = CNT_W'(i_page_index) + i_page_count - CNT_W'(1);
    end

    // Word evaluation for allocate: lowest free page inside the tracked range.
    always_comb begin
        alloc_mask = '1;
        if (r_rd_word == r_alloc_hi[PAGE_W-1:BIT_W]) begin
            alloc_mask = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - r_alloc_hi[BIT_W-1:0]);
        end
        avail    = ~r_rd_data & alloc_mask;
        free_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (avail[i]) begin
                free_bit = BIT_W'(i);
            end
        end
    end

    // Word evaluation for free: bits of the run that fall in this word.
    always_comb begin
        lo = (r_rd_word == r_first[PAGE_W-1:BIT_W]) ? r_first[BIT_W-1:0] : '0;
        hi = (r_rd_word == r_last[PAGE_W-1:BIT_W]) ? r_last[BIT_W-1:0] : '1;
        run_mask = ({WORD_BITS{1'b1}} << lo) &
                   ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi));
        end_word = r_op ? r_last[PAGE_W-1:BIT_W] : r_alloc_hi[PAGE_W-1:BIT_W];
    end

    // Status toward the controller.
    always_comb begin
        o_sts.op_free     = r_op;
        o_sts.lim_zero    = r_lim_zero;
        o_sts.cnt_zero    = r_cnt_zero;
        o_sts.range_err   = r_range_err;
        o_sts.eval_last   = (r_rd_word == end_word);
        o_sts.alloc_found = |avail;
        o_sts.free_ok     = ((r_rd_data & run_mask) == run_mask);
    end

    // Read-modify-write data back into the word just read.
    always_comb begin
        wr_en   = i_cmd.wr_alloc | i_cmd.wr_clear;
        wr_data = i_cmd.wr_alloc ? (r_rd_data | (WORD_BITS'(1) << free_bit))
                                 : (r_rd_data & ~run_mask);
    end

    // Bitmap memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_rd_word] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_row_vld[r_addr] ? mem[r_addr] : '0;
            r_rd_word <= r_addr;
        end
    end

    // Row valid bits, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[r_rd_word] <= 1'b1;
        end
    end

    // Word address counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_operation ? i_page_index[PAGE_W-1:BIT_W] : '0;
        end else if (i_cmd.addr_reload) begin
            r_addr <= r_first[PAGE_W-1:BIT_W];
        end else if (i_cmd.addr_step) begin
            r_addr <= r_addr + WORD_W'(1);
        end
    end

    // Item registers captured on accept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_operation;
            r_first     <= i_page_index;
            r_count     <= i_page_count;
            r_last      <= last_full[PAGE_W-1:0];
            r_alloc_hi  <= lim_m1[PAGE_W-1:0];
            r_lim_zero  <= (lim == '0);
            r_cnt_zero  <= (i_page_count == '0);
            r_range_err <= (run_end > {1'b0, lim});
        end
    end

    // Granted page, zero unless an allocate succeeds.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_granted <= '0;
        end else if (i_cmd.wr_alloc) begin
            r_granted <= {r_rd_word, free_bit};
        end
    end

    // Used-page counter and tracked-entry register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_entries <= PAGES_C;
        end else begin
            if (i_cmd.wr_alloc) begin
                r_total <= r_total + CNT_W'(1);
            end else if (i_cmd.total_sub) begin
                r_total <= r_total - r_count;
            end
            if (i_cfg_we) begin
                r_entries <= i_cfg_data;
            end
        end
    end

    assign o_granted = r_granted;
    assign o_total   = r_total;

endmodule

`default_nettype wire

// ===== rtl/core/bpa_ctrl.sv =====
// ============================================================================
// bpa_ctrl
// Controller of the bitmap page allocator: sequences the word scan of an
// allocate and the check and clear passes of a free, and sets the result.
// ============================================================================
`default_nettype none

module bpa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire bpa_pkg::t_dp_sts  i_sts,
    output bpa_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy,
    output logic                   o_done,
    output bpa_pkg::t_status       o_status
);
    import bpa_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_status r_status;
    t_status n_status;

    // Next state and result code.
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (!i_sts.op_free) begin
                    if (i_sts.lim_zero) begin
                        n_state  = S_DONE;
                        n_status = ST_FULL;
                    end else begin
                        n_state = S_ASCAN;
                    end
                end else if (i_sts.range_err) begin
                    n_state  = S_DONE;
                    n_status = ST_ERROR;
                end else if (i_sts.cnt_zero) begin
                    n_state  = S_DONE;
                    n_status = ST_OK;
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_ASCAN: begin
                if (i_sts.alloc_found) begin
                    n_state  = S_DONE;
                    n_status = ST_OK;
                end else if (i_sts.eval_last) begin
                    n_state  = S_DONE;
                    n_status = ST_FULL;
                end
            end
            S_FCHK: begin
                if (!i_sts.free_ok) begin
                    n_state  = S_DONE;
                    n_status = ST_ERROR;
                end else if (i_sts.eval_last) begin
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                n_state = S_CCLR;
            end
            S_CCLR: begin
                if (i_sts.eval_last) begin
                    n_state  = S_DONE;
                    n_status = ST_OK;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_SETUP: begin
                if ((!i_sts.op_free && !i_sts.lim_zero) ||
                    (i_sts.op_free && !i_sts.range_err && !i_sts.cnt_zero)) begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.addr_step = 1'b1;
                end
            end
            S_ASCAN: begin
                if (i_sts.alloc_found) begin
                    o_cmd.wr_alloc = 1'b1;
                end else if (!i_sts.eval_last) begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.addr_step = 1'b1;
                end
            end
            S_FCHK: begin
                if (i_sts.free_ok && i_sts.eval_last) begin
                    o_cmd.addr_reload = 1'b1;
                end else if (i_sts.free_ok) begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.addr_step = 1'b1;
                end
            end
            S_CRD: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.addr_step = 1'b1;
            end
            S_CCLR: begin
                o_cmd.wr_clear = 1'b1;
                if (i_sts.eval_last) begin
                    o_cmd.total_sub = 1'b1;
                end else begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.addr_step = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_status = r_status;

    // The result strobe is always followed by a return to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy)
        else $error("controller did not return to idle after a result");

    // An accepted item makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not start the controller");

    // Memory writes only happen in the allocate scan or the clear pass.
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr_alloc || o_cmd.wr_clear) |-> (r_state == S_ASCAN || r_state == S_CCLR))
        else $error("bitmap write outside a writing state");

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_page_allocator.sv =====
// ============================================================================
// bitmap_page_allocator
// First-fit page allocator over a 4096-page used bitmap held in 64 words of
// 64 bits; allocates one page or frees a run of pages per item.
// ============================================================================
//
//  Channel   Direction  Signals                                   Handshake
//  --------  ---------  ----------------------------------------  ---------------
//  command   in         i_operation, i_page_index, i_page_count   start & !busy
//  result    out        o_status, o_granted_index, o_pages_used   o_done strobe
//  config    in         i_cfg_entries_in_use                      valid & ready
//
//  An allocate passes a setup state, then examines one memory word a cycle,
//  scanning at most 64 bitmap words. A free of a run raises o_done after a
//  check pass, a state to reread the first word and a clear pass over the
//  memory's single read and write ports. A range error, an empty run or zero
//  tracked entries answers straight from the setup state. busy drops the
//  cycle after o_done, so a new item is taken only once the last is through.
//  Reset clears the bitmap at once through per-word valid bits; no sweep.
//  Results are shown for one cycle with o_done; the receiver cannot stall.
// ============================================================================
`default_nettype none

module bitmap_page_allocator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_operation,
    input  wire logic [bpa_pkg::PAGE_W-1:0] i_page_index,
    input  wire logic [bpa_pkg::CNT_W-1:0]  i_page_count,
    output logic                            o_done,
    output logic [1:0]                      o_status,
    output logic [bpa_pkg::PAGE_W-1:0]      o_granted_index,
    output logic [bpa_pkg::CNT_W-1:0]       o_pages_used,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [bpa_pkg::CNT_W-1:0]  i_cfg_entries_in_use
);
    import bpa_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_status status;

    // Sequencing.
    bpa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (dp_sts),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_status (status)
    );

    // Bitmap, counters and configuration.
    bpa_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_operation  (i_operation),
        .i_page_index (i_page_index),
        .i_page_count (i_page_count),
        .i_cfg_we     (i_cfg_valid & o_cfg_ready),
        .i_cfg_data   (i_cfg_entries_in_use),
        .o_granted    (o_granted_index),
        .o_total      (o_pages_used)
    );

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign o_status    = status;

    // A non-ok result never carries a granted page.
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && status != ST_OK) |-> (o_granted_index == '0))
        else $error("granted page reported on a failed item");

    // The used count never exceeds the bitmap size.
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_pages_used <= CNT_W'(PAGES)))
        else $error("used page count out of range");

    // A successful allocate raises the used count by one.
    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.wr_alloc |=> (o_pages_used == $past(o_pages_used) + CNT_W'(1)))
        else $error("used page count not advanced on allocate");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: bitmap page allocator
// Drives allocate and free commands into the allocator and checks every
// result strobe against a shadow copy of the used-page bitmap, the used-page
// count and the entry limit. Directed corner cases come first, then random
// traffic under three sender idle patterns and a fill of a small tracked range.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int SETTLE_TIME  = 140;
    localparam int CHUNK_ITEMS  = 25;
    localparam int CHUNKS       = 5;
    localparam int FILL_LIMIT   = 130;

    // One expected result of the allocator.
    typedef struct packed {
        t_status             status;
        logic [PAGE_W-1:0]   granted;
        logic [CNT_W-1:0]    used;
    } t_page_outcome;

    logic                i_clk;
    logic                i_rst_n              = 1'b0;
    logic                start                = 1'b0;
    logic                busy;
    logic                i_operation          = 1'b0;
    logic [PAGE_W-1:0]   i_page_index         = '0;
    logic [CNT_W-1:0]    i_page_count         = '0;
    logic                o_done;
    logic [1:0]          o_status;
    logic [PAGE_W-1:0]   o_granted_index;
    logic [CNT_W-1:0]    o_pages_used;
    logic                i_cfg_valid          = 1'b0;
    logic                o_cfg_ready;
    logic [CNT_W-1:0]    i_cfg_entries_in_use = '0;

    // Shadow state of the allocator.
    bit                  shadow_used [PAGES];
    logic [CNT_W-1:0]    shadow_total   = '0;
    logic [CNT_W-1:0]    shadow_entries = 13'd4096;

    t_page_outcome       awaited_outcomes [$];
    t_page_outcome       oldest;

    int                  sender_idle_pct = 0;
    int                  mismatch_count  = 0;
    int                  cycle_count     = 0;
    int                  item_count      = 0;
    int                  grant_count     = 0;
    int                  full_count      = 0;
    int                  release_count   = 0;
    int                  reject_count    = 0;
    int                  limit_writes    = 0;

    bitmap_page_allocator uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_operation          (i_operation),
        .i_page_index         (i_page_index),
        .i_page_count         (i_page_count),
        .o_done               (o_done),
        .o_status             (o_status),
        .o_granted_index      (o_granted_index),
        .o_pages_used         (o_pages_used),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_entries_in_use (i_cfg_entries_in_use)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Pages the bitmap scan may touch; limits above the map size saturate.
    function automatic int tracked_limit();
        return (int'(shadow_entries) > PAGES) ? PAGES : int'(shadow_entries);
    endfunction

    // True while some page below the limit is still free.
    function automatic bit map_has_room();
        int p;
        for (p = 0; p < tracked_limit(); p++)
            if (!shadow_used[p]) return 1'b1;
        return 1'b0;
    endfunction

    // Applies one command to the shadow state and returns the result it gives.
    function automatic t_page_outcome allocator_outcome(input t_op op,
                                                        input logic [PAGE_W-1:0] idx,
                                                        input logic [CNT_W-1:0] cnt);
        t_page_outcome r;
        int            limit;
        int            last;
        int            p;
        limit     = tracked_limit();
        r.status  = ST_OK;
        r.granted = '0;
        if (op == OP_ALLOC) begin
            p = 0;
            while (p < limit && shadow_used[p]) p++;
            if (p < limit) begin
                shadow_used[p] = 1'b1;
                shadow_total   = shadow_total + 1'b1;
                r.granted      = p[PAGE_W-1:0];
            end else begin
                r.status = ST_FULL;
            end
        end else begin
            last = int'(idx) + int'(cnt);
            if (last > limit) begin
                r.status = ST_ERROR;
            end else begin
                // All or nothing: any free page in the run rejects the whole run.
                for (p = int'(idx); p < last; p++)
                    if (!shadow_used[p]) r.status = ST_ERROR;
                if (r.status == ST_OK) begin
                    for (p = int'(idx); p < last; p++) shadow_used[p] = 1'b0;
                    shadow_total = shadow_total - cnt;
                end
            end
        end
        r.used = shadow_total;
        return r;
    endfunction

    // Offers one item, idling at random, and records its expected result.
    task automatic send_item(input t_op op, input logic [PAGE_W-1:0] idx,
                             input logic [CNT_W-1:0] cnt);
        t_page_outcome r;
        forever begin
            start        <= ($urandom_range(99) >= sender_idle_pct);
            i_operation  <= op;
            i_page_index <= idx;
            i_page_count <= cnt;
            @(posedge i_clk);
            if (start && !busy) break;
        end
        r = allocator_outcome(op, idx, cnt);
        awaited_outcomes.push_back(r);
        item_count++;
        case (r.status)
            ST_OK:   if (op == OP_ALLOC) grant_count++; else release_count++;
            ST_FULL: full_count++;
            default: reject_count++;
        endcase
    endtask

    // Holds the sender off until every expected result has been seen.
    task automatic wait_all_results();
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_outcomes.size() != 0);
    endtask

    task automatic write_entry_limit(input logic [CNT_W-1:0] value);
        wait_all_results();
        while (busy) @(posedge i_clk);
        i_cfg_valid          <= 1'b1;
        i_cfg_entries_in_use <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        shadow_entries  = value;
        limit_writes++;
    endtask

    // Finds a run of used pages below the limit, starting at a random place.
    function automatic bit pick_used_run(output int first, output int len);
        int limit;
        int origin;
        int k;
        int p;
        int run;
        limit = tracked_limit();
        first = 0;
        len   = 0;
        if (limit == 0 || shadow_total == 0) return 1'b0;
        origin = $urandom_range(limit - 1);
        for (k = 0; k < limit; k++) begin
            p = (origin + k) % limit;
            if (shadow_used[p]) break;
        end
        if (k == limit) return 1'b0;
        run = 0;
        while (p + run < limit && shadow_used[p + run]) run++;
        first = p;
        len   = ($urandom_range(3) == 0) ? run : $urandom_range(run, 1);
        return 1'b1;
    endfunction

    // One random item: mostly allocates and frees of real runs, some broken
    // runs and some raw noise.
    task automatic random_item();
        int pick;
        int first;
        int len;
        logic [PAGE_W-1:0] idx;
        logic [CNT_W-1:0]  cnt;
        pick = $urandom_range(99);
        idx  = PAGE_W'($urandom_range(PAGES - 1));
        cnt  = ($urandom_range(1) == 0) ? CNT_W'($urandom_range(8))
                                        : CNT_W'($urandom_range(8191));
        if (pick < 45 || (pick < 90 && !pick_used_run(first, len))) begin
            send_item(OP_ALLOC, idx, cnt);
        end else if (pick < 80) begin
            send_item(OP_FREE, PAGE_W'(first), CNT_W'(len));
        end else if (pick < 90) begin
            // Run grown by one page at either end.
            if (first > 0 && $urandom_range(1) == 1)
                send_item(OP_FREE, PAGE_W'(first - 1), CNT_W'(len + 1));
            else
                send_item(OP_FREE, PAGE_W'(first), CNT_W'(len + 1));
        end else begin
            send_item(OP_FREE, idx, cnt);
        end
    endtask

    function automatic logic [CNT_W-1:0] chunk_limit(input int k);
        case (k % 8)
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd64;
            3:       return 13'd65;
            4:       return 13'd4096;
            5:       return 13'd8191;
            6:       return CNT_W'($urandom_range(4095, 2));
            default: return CNT_W'($urandom_range(8191, 4097));
        endcase
    endfunction

    // Corner cases at the reset limit, at zero entries and at a single entry.
    task automatic test_directed_cases();
        sender_idle_pct = 0;
        send_item(OP_FREE,  12'd0,    13'd0);     // empty run is fine
        send_item(OP_FREE,  12'd0,    13'd1);     // page already free
        send_item(OP_ALLOC, 12'd4095, 13'd8191);  // free fields are ignored
        send_item(OP_ALLOC, 12'd0,    13'd0);
        send_item(OP_ALLOC, 12'd2730, 13'd5461);
        send_item(OP_FREE,  12'd1,    13'd3);     // run reaches a free page
        send_item(OP_FREE,  12'd1,    13'd1);
        send_item(OP_ALLOC, 12'd0,    13'd0);     // hole is reused first
        send_item(OP_FREE,  12'd0,    13'd3);
        send_item(OP_FREE,  12'd4095, 13'd1);
        send_item(OP_FREE,  12'd4095, 13'd2);     // run past the limit
        send_item(OP_FREE,  12'd0,    13'd8191);
        send_item(OP_FREE,  12'd0,    13'd4096);
        send_item(OP_FREE,  12'd4095, 13'd0);
        write_entry_limit(13'd0);
        send_item(OP_ALLOC, 12'd0,    13'd0);     // no pages at all
        send_item(OP_FREE,  12'd0,    13'd0);
        send_item(OP_FREE,  12'd0,    13'd1);
        write_entry_limit(13'd1);
        send_item(OP_ALLOC, 12'd0,    13'd0);
        send_item(OP_ALLOC, 12'd0,    13'd0);     // single page is taken
        send_item(OP_FREE,  12'd0,    13'd1);
        send_item(OP_FREE,  12'd0,    13'd1);     // double free
        send_item(OP_ALLOC, 12'd0,    13'd0);
    endtask

    // Random traffic in chunks, each under its own entry limit.
    task automatic test_random_traffic(input int idle_pct, input int phase);
        int c;
        int n;
        sender_idle_pct = idle_pct;
        for (c = 0; c < CHUNKS; c++) begin
            write_entry_limit(chunk_limit(phase * CHUNKS + c));
            for (n = 0; n < CHUNK_ITEMS; n++) begin
                random_item();
                if (n == CHUNK_ITEMS / 2 || $urandom_range(49) == 0) wait_all_results();
            end
        end
    endtask

    // Fills every page below a limit spanning three words, then works at its
    // top edge and across word boundaries.
    task automatic test_full_map();
        sender_idle_pct = 0;
        write_entry_limit(CNT_W'(FILL_LIMIT));
        while (map_has_room()) send_item(OP_ALLOC, 12'd0, 13'd0);
        send_item(OP_ALLOC, 12'd0,    13'd0);     // range is full
        send_item(OP_FREE,  12'd129,  13'd1);
        send_item(OP_ALLOC, 12'd0,    13'd0);
        send_item(OP_FREE,  12'd64,   13'd66);    // crosses into the third word
        send_item(OP_FREE,  12'd0,    13'd131);   // run past the limit
        send_item(OP_FREE,  12'd0,    13'd64);
        send_item(OP_ALLOC, 12'd0,    13'd0);
        send_item(OP_FREE,  12'd0,    13'd1);
    endtask

    // Result checker: every strobe against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0) begin
            if (awaited_outcomes.size() == 0) begin
                report_mismatch("result with no item pending", o_status, 0);
            end else begin
                oldest = awaited_outcomes.pop_front();
                if (o_status !== oldest.status)
                    report_mismatch("status", o_status, oldest.status);
                if (o_granted_index !== oldest.granted)
                    report_mismatch("granted index", o_granted_index, oldest.granted);
                if (o_pages_used !== oldest.used)
                    report_mismatch("pages used", o_pages_used, oldest.used);
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_traffic(18, 0);
        test_random_traffic(85, 1);
        test_random_traffic(0, 2);
        test_full_map();

        wait_all_results();
        repeat (SETTLE_TIME) @(posedge i_clk);
        if (awaited_outcomes.size() != 0)
            report_mismatch("results never delivered", 0, awaited_outcomes.size());

        $display("Ran %0d items: %0d grants, %0d full refusals, %0d frees, %0d rejected frees.",
                 item_count, grant_count, full_count, release_count, reject_count);
        $display("Entry limit written %0d times from 0 to 8191; the first %0d pages filled.",
                 limit_writes, FILL_LIMIT);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
